// ===== hdl/fc2d_pkg.sv =====
package fc2d_pkg;

  // Default sizes for the top-level parameters
  localparam int KMAX_DEF       = 7;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Fixed field widths
  localparam int PIXEL_BITS = 16;
  localparam int COEF_BITS  = 16;
  localparam int RES_BITS   = 40;
  localparam int CIDX_BITS  = 6;
  localparam int DIM_BITS   = 11;
  localparam int KSIZE_BITS = 3;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = DIM_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_SIZE  = 2'd2;

  // Opcodes
  localparam logic OP_LOAD_COEF = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  // Reset values of the registers
  localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 11'd1024;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 11'd1024;
  localparam logic [KSIZE_BITS-1:0] KSIZE_RST  = 3'd3;

  typedef struct packed {
    logic                          opcode;
    logic [CIDX_BITS-1:0]          coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [PIXEL_BITS-1:0]  pixel;
  } fc2d_in_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] result_value;
    logic                       frame_last;
  } fc2d_out_t;

endpackage

// ===== hdl/full_2d_convolution_stream_top.sv =====
// An accepted pixel passes the stage 1 to 4 and output registers before out_valid.
// Throughput: one transaction per cycle; the row buffer takes one column read and one
// pixel write per cycle, and the window multiplies all taps in parallel.
// A stalled result holds the whole pipeline. Reset clears the position counters,
// coefficients and pipeline valids, and sets the registers to their defaults; the row
// buffer is not cleared, rows and columns outside the image are masked to zero.
module full_2d_convolution_stream_top #(
  parameter int KMAX       = fc2d_pkg::KMAX_DEF,
  parameter int MAX_WIDTH  = fc2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fc2d_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fc2d_pkg::fc2d_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fc2d_pkg::fc2d_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fc2d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fc2d_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fc2d_pkg::*;

  localparam int ROW_LEN = MAX_WIDTH + KMAX - 1;
  localparam int NTAP    = KMAX * KMAX;
  localparam int CW      = $clog2(ROW_LEN + 1);
  localparam int RW      = $clog2(MAX_HEIGHT + KMAX);
  localparam int AW      = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int LW      = (KMAX > 1) ? $clog2(KMAX) : 1;
  localparam int NW      = $clog2(KMAX + 1);
  localparam int PW      = PIXEL_BITS + COEF_BITS;

  // Configuration registers
  logic [DIM_BITS-1:0]   width_cfg_r;
  logic [DIM_BITS-1:0]   height_cfg_r;
  logic [KSIZE_BITS-1:0] ksize_cfg_r;

  // Clamped extents
  logic [CW-1:0] w_eff, ew_eff;
  logic [RW-1:0] h_eff, eh_eff;
  logic [NW-1:0] n_eff;

  // Stage 0 position state
  logic [RW-1:0] out_row_r, out_row_nxt, r0;
  logic [CW-1:0] out_col_r, out_col_nxt, c0;
  logic [LW-1:0] rmod_r, rmod_nxt, rmod0;
  logic signed [PIXEL_BITS-1:0] v0;
  logic last0;

  logic en, accept, acc_pix;

  // Row buffer: one entry per column, one lane per ring row
  logic [PIXEL_BITS-1:0] rowbuf [ROW_LEN][KMAX];
  logic [PIXEL_BITS-1:0] rd_r [KMAX];

  // Stage 1
  logic                         s1_valid_r, s1_pix_r, s1_last_r;
  logic [CIDX_BITS-1:0]         s1_cidx_r;
  logic signed [COEF_BITS-1:0]  s1_cval_r;
  logic signed [PIXEL_BITS-1:0] s1_v_r;
  logic [LW-1:0]                s1_rmod_r;
  logic [RW-1:0]                s1_r_r;
  logic [CW-1:0]                s1_c_r;
  logic signed [PIXEL_BITS-1:0] fixed_col [KMAX];
  logic signed [PIXEL_BITS-1:0] colv [KMAX];

  // Window: win_r[a][j], j is the column age (0 is the newest column)
  logic signed [PIXEL_BITS-1:0] win_r [KMAX][KMAX];

  // Stage 2
  logic                        s2_valid_r, s2_pix_r, s2_last_r;
  logic [CIDX_BITS-1:0]        s2_cidx_r;
  logic signed [COEF_BITS-1:0] s2_cval_r;
  logic [CW-1:0]               s2_c_r;
  logic signed [COEF_BITS-1:0] coef_r [NTAP];
  logic signed [RES_BITS-1:0]  prod_nxt [KMAX][KMAX];

  // Stage 3 and 4
  logic                       s3_valid_r, s3_last_r;
  logic signed [RES_BITS-1:0] prod_r [KMAX][KMAX];
  logic signed [RES_BITS-1:0] rowsum_nxt [KMAX];
  logic                       s4_valid_r, s4_last_r;
  logic signed [RES_BITS-1:0] rowsum_r [KMAX];
  logic signed [RES_BITS-1:0] total_nxt;

  // Output register
  logic      out_valid_r;
  fc2d_out_t out_data_r;

  // Handshake: the pipeline advances unless a result is held by the sink
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign acc_pix   = accept && (in_data.opcode == OP_PIXEL);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
      ksize_cfg_r  <= KSIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_cfg_r <= cfg_data;
        REG_KERNEL_SIZE:  ksize_cfg_r  <= cfg_data[KSIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers into range and derive the extended frame
  always_comb begin
    int wi, hi, ni;
    wi = int'(width_cfg_r);
    hi = int'(height_cfg_r);
    ni = int'(ksize_cfg_r);
    if (wi < 1) wi = 1;
    if (wi > MAX_WIDTH) wi = MAX_WIDTH;
    if (hi < 1) hi = 1;
    if (hi > MAX_HEIGHT) hi = MAX_HEIGHT;
    if (ni < 1) ni = 1;
    if (ni > KMAX) ni = KMAX;
    w_eff  = CW'(wi);
    h_eff  = RW'(hi);
    n_eff  = NW'(ni);
    ew_eff = CW'(wi + ni - 1);
    eh_eff = RW'(hi + ni - 1);
  end

  // Stage 0: current position, masked pixel and next position
  always_comb begin
    logic restart;
    restart = (out_row_r >= eh_eff) || (out_col_r >= ew_eff);
    r0      = restart ? '0 : out_row_r;
    c0      = restart ? '0 : out_col_r;
    rmod0   = restart ? '0 : rmod_r;
    v0      = ((r0 < h_eff) && (c0 < w_eff)) ? in_data.pixel : '0;
    last0   = (r0 == eh_eff - RW'(1)) && (c0 == ew_eff - CW'(1));
    out_row_nxt = r0;
    out_col_nxt = c0 + CW'(1);
    rmod_nxt    = rmod0;
    if ({1'b0, c0} + (CW+1)'(1) >= {1'b0, ew_eff}) begin
      out_col_nxt = '0;
      if ({1'b0, r0} + (RW+1)'(1) >= {1'b0, eh_eff}) begin
        out_row_nxt = '0;
        rmod_nxt    = '0;
      end else begin
        out_row_nxt = r0 + RW'(1);
        rmod_nxt    = (rmod0 == LW'(KMAX - 1)) ? '0 : rmod0 + LW'(1);
      end
    end
  end

  // Advance the position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_row_r <= '0;
      out_col_r <= '0;
      rmod_r    <= '0;
    end else if (acc_pix) begin
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      rmod_r    <= rmod_nxt;
    end
  end

  // Row buffer: write the new pixel into its ring lane, read the whole column
  always_ff @(posedge clk) begin
    if (acc_pix) begin
      rowbuf[c0[AW-1:0]][rmod0] <= v0;
    end
    if (en) begin
      rd_r <= rowbuf[c0[AW-1:0]];
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix_r  <= in_data.opcode == OP_PIXEL;
      s1_cidx_r <= in_data.coef_index;
      s1_cval_r <= in_data.coef_value;
      s1_v_r    <= v0;
      s1_rmod_r <= rmod0;
      s1_r_r    <= r0;
      s1_c_r    <= c0;
      s1_last_r <= last0;
    end
  end

  // Stage 1: forward the pixel written in the same cycle, then pick the ring lanes
  always_comb begin
    int t;
    for (int l = 0; l < KMAX; l++) begin
      fixed_col[l] = (LW'(l) == s1_rmod_r) ? s1_v_r : $signed(rd_r[l]);
    end
    for (int a = 0; a < KMAX; a++) begin
      t = int'(s1_rmod_r) + KMAX + a + 1 - int'(n_eff);
      if (t >= KMAX) t = t - KMAX;
      if ((a < int'(n_eff)) && (int'(s1_r_r) + a + 1 >= int'(n_eff))) begin
        colv[a] = fixed_col[LW'(t)];
      end else begin
        colv[a] = '0;
      end
    end
  end

  // Shift the new column into the window
  always_ff @(posedge clk) begin
    if (en && s1_valid_r && s1_pix_r) begin
      for (int a = 0; a < KMAX; a++) begin
        win_r[a][0] <= colv[a];
        for (int j = 1; j < KMAX; j++) begin
          win_r[a][j] <= win_r[a][j-1];
        end
      end
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pix_r  <= s1_pix_r;
      s2_cidx_r <= s1_cidx_r;
      s2_cval_r <= s1_cval_r;
      s2_c_r    <= s1_c_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Load coefficients in item order, behind any earlier window still in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NTAP; i++) begin
        coef_r[i] <= '0;
      end
    end else if (en && s2_valid_r && !s2_pix_r && (int'(s2_cidx_r) < NTAP)) begin
      coef_r[s2_cidx_r] <= s2_cval_r;
    end
  end

  // Stage 2: multiply each live tap; the newest column meets kernel column n-1
  always_comb begin
    int ci;
    logic signed [PW-1:0] p;
    for (int a = 0; a < KMAX; a++) begin
      for (int j = 0; j < KMAX; j++) begin
        ci = (a + 1) * int'(n_eff) - 1 - j;
        p  = '0;
        if ((a < int'(n_eff)) && (j < int'(n_eff)) && (j <= int'(s2_c_r)) &&
            (ci >= 0) && (ci < NTAP)) begin
          p = win_r[a][j] * coef_r[ci];
        end
        prod_nxt[a][j] = RES_BITS'(p);
      end
    end
  end

  // Stage 3, stage 4 and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r  <= s2_valid_r && s2_pix_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= prod_nxt;
      s3_last_r <= s2_last_r;
      rowsum_r  <= rowsum_nxt;
      s4_last_r <= s3_last_r;
      out_data_r.result_value <= total_nxt;
      out_data_r.frame_last   <= s4_last_r;
    end
  end

  // Stage 3: sum each kernel row
  always_comb begin
    for (int a = 0; a < KMAX; a++) begin
      rowsum_nxt[a] = '0;
      for (int j = 0; j < KMAX; j++) begin
        rowsum_nxt[a] = rowsum_nxt[a] + prod_r[a][j];
      end
    end
  end

  // Stage 4: sum the rows
  always_comb begin
    total_nxt = '0;
    for (int a = 0; a < KMAX; a++) begin
      total_nxt = total_nxt + rowsum_r[a];
    end
  end

endmodule

// ===== test/full_2d_convolution_stream_top_test.sv =====
module full_2d_convolution_stream_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fc2d_pkg::*;

  localparam int KM      = KMAX_DEF;
  localparam int ROW_LEN = MAX_WIDTH_DEF + KMAX_DEF - 1;

  // Track the filter state and the window sums still owed by the block
  class conv_scoreboard;
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    logic [KSIZE_BITS-1:0] ksize_reg;
    logic signed [COEF_BITS-1:0] coef [KM*KM];
    int          line_buf [KM][ROW_LEN];
    int unsigned pos_row;
    int unsigned pos_col;
    fc2d_out_t   owed_sums [$];
    int          errors;
    int          checked;
    int          frames;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      ksize_reg  = KSIZE_RST;
      foreach (coef[i]) coef[i] = '0;
      foreach (line_buf[i, j]) line_buf[i][j] = 0;
      pos_row = 0;
      pos_col = 0;
      errors  = 0;
      checked = 0;
      frames  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = data;
        REG_IMAGE_HEIGHT: height_reg = data;
        REG_KERNEL_SIZE:  ksize_reg  = data[KSIZE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Note one accepted transaction: load a coefficient or predict a pixel's window sum
    function void note_input(fc2d_in_t t);
      int unsigned w, h, n, ew, eh, r, c;
      int          v, tap;
      longint      acc;
      fc2d_out_t   e;
      w  = clip(width_reg, MAX_WIDTH_DEF);
      h  = clip(height_reg, MAX_HEIGHT_DEF);
      n  = clip(ksize_reg, KM);
      ew = w + n - 1;
      eh = h + n - 1;
      if (t.opcode == OP_LOAD_COEF) begin
        if (t.coef_index < KM*KM) coef[t.coef_index] = $signed(t.coef_value);
        return;
      end
      // Restart when the position fell outside the current extents
      if (pos_row >= eh || pos_col >= ew) begin
        pos_row = 0;
        pos_col = 0;
      end
      r = pos_row;
      c = pos_col;
      v = (r < h && c < w) ? int'($signed(t.pixel)) : 0;
      line_buf[r % KM][c] = v;
      acc = 0;
      for (int a = 0; a < n; a++) begin
        for (int b = 0; b < n; b++) begin
          tap = 0;
          if (r + a + 1 >= n && c + b + 1 >= n)
            tap = line_buf[(r + a + 1 - n) % KM][c + b + 1 - n];
          acc += longint'(tap) * longint'(coef[a*n + b]);
        end
      end
      e.result_value = acc[RES_BITS-1:0];
      e.frame_last   = (r == eh - 1) && (c == ew - 1);
      owed_sums.push_back(e);
      // Advance the raster position
      if (c + 1 >= ew) begin
        pos_col = 0;
        pos_row = (r + 1 >= eh) ? 0 : r + 1;
      end else begin
        pos_col = c + 1;
      end
    endfunction

    function void check_result(fc2d_out_t got);
      fc2d_out_t e;
      if (owed_sums.size() == 0) begin
        $error("unexpected result: result_value %0d frame_last %0d",
               got.result_value, got.frame_last);
        errors++;
        return;
      end
      e = owed_sums.pop_front();
      checked++;
      if (got.frame_last) frames++;
      if (got.result_value !== e.result_value) begin
        $error("result_value: expected %0d, actual %0d", e.result_value, got.result_value);
        errors++;
      end
      if (got.frame_last !== e.frame_last) begin
        $error("frame_last: expected %0d, actual %0d", e.frame_last, got.frame_last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_sums.size();
    endfunction

    function int unsigned frame_len();
      int unsigned n;
      n = clip(ksize_reg, KM);
      return (clip(width_reg, MAX_WIDTH_DEF) + n - 1) * (clip(height_reg, MAX_HEIGHT_DEF) + n - 1);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  fc2d_in_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  fc2d_out_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  conv_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  int items_sent;
  int quiet_cycles;

  full_2d_convolution_stream_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Check results and stall the result channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= rst_n && ($urandom_range(99) < rx_stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("full_2d_convolution_stream_top_test: done, errors");
      $finish;
    end
  end

  // Send one transaction after a random gap
  task automatic send(fc2d_in_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
    items_sent++;
  endtask

  task automatic send_coef(int unsigned idx, logic [COEF_BITS-1:0] val);
    fc2d_in_t t;
    t.opcode     = OP_LOAD_COEF;
    t.coef_index = CIDX_BITS'(idx);
    t.coef_value = val;
    t.pixel      = PIXEL_BITS'($urandom);
    send(t);
  endtask

  task automatic send_pixel(logic [PIXEL_BITS-1:0] val);
    fc2d_in_t t;
    t.opcode     = OP_PIXEL;
    t.coef_index = CIDX_BITS'($urandom);
    t.coef_value = COEF_BITS'($urandom);
    t.pixel      = val;
    send(t);
  endtask

  // Drop valid and wait until every owed sum has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(int w, int h, int k);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(REG_KERNEL_SIZE, CFG_DATA_BITS'(k));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned n, len, phase;
    sb = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Small frame with extreme coefficients and pixels; index past the store is dropped
    configure(3, 2, 2);
    send_coef(0, 16'h7fff);
    send_coef(1, 16'h8000);
    send_coef(2, 16'h0001);
    send_coef(3, 16'hffff);
    send_coef(63, 16'h1234);
    send_pixel(16'h7fff);
    send_pixel(16'h8000);
    send_pixel(16'h8000);
    send_pixel(16'h5a5a);
    send_pixel(16'h7fff);
    send_pixel(16'h7fff);
    send_pixel(16'ha5a5);
    repeat (5) send_pixel(PIXEL_BITS'($urandom));
    drain();

    // Shrink the frame mid-raster so the position restarts at the origin
    configure(8, 4, 3);
    repeat (12) send_pixel(PIXEL_BITS'($urandom));
    drain();
    configure(0, 0, 0);
    repeat (3) send_pixel(PIXEL_BITS'($urandom));
    drain();

    // Oversized width and height clamp to the maximum; run part of each frame
    configure(2047, 1, 1);
    send_coef(0, 16'h4000);
    repeat (64) send_pixel(PIXEL_BITS'($urandom));
    drain();
    configure(1, 2047, 1);
    repeat (64) send_pixel(PIXEL_BITS'($urandom));
    drain();

    // Random frames with fresh settings and kernels, cycling the idle pattern
    phase = 0;
    while (items_sent < 650) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      n = $urandom_range(7);
      configure($urandom_range(1, 12), $urandom_range(1, 6), n);
      if (n == 0) n = 1;
      for (int i = 0; i < n*n; i++) send_coef(i, rand_word());
      len = sb.frame_len();
      for (int i = 0; i < len; i++) begin
        // Hold off once until the pipeline is empty
        if (phase == 3 && i == len / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() > 0);
        end
        if ($urandom_range(9) == 0) send_coef($urandom_range(63), rand_word());
        send_pixel(rand_word());
      end
      drain();
      phase++;
    end

    $display("covered %0d transactions, %0d window sums over %0d frames, %0d random phases",
             items_sent, sb.checked, sb.frames, phase);
    $display("with clamped and restarted frames, kernel sizes 1 to 7 and mixed stalls");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("full_2d_convolution_stream_top_test: done, clean");
    else
      $display("full_2d_convolution_stream_top_test: done, errors");
    $finish;
  end

endmodule
